/* sv/kmid_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmid_pkg
// types and constants shared by the key matrix debouncer files
// ---------------------------------------------------------------------------
package kmid_pkg;

   localparam int unsigned KEY_WIDTH    = 32;
   localparam int unsigned TIME_WIDTH   = 32;
   localparam int unsigned COUNT_WIDTH  = 8;
   localparam int unsigned PERIOD_WIDTH = 16;
   localparam int unsigned CSR_AW       = 3;
   localparam int unsigned CSR_DW       = 32;

   localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX       = '1;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET    = 16'd1;
   localparam logic [COUNT_WIDTH-1:0]  THRESHOLD_RESET = 8'd5;

   typedef enum logic [0:0] {
      REG_SCAN_PERIOD     = 1'b0,
      REG_PRESS_THRESHOLD = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [PERIOD_WIDTH-1:0] scan_period;
      logic [COUNT_WIDTH-1:0]  press_threshold;
   } cfg_type;

endpackage

/* sv/kmid_req_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmid_req_if
// request channel: timestamp and raw pressed-key bitmap
// ---------------------------------------------------------------------------
interface kmid_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] time_ms;
   logic [31:0] raw_pressed;

   modport source (output valid, output time_ms, output raw_pressed, input ready);
   modport sink   (input valid, input time_ms, input raw_pressed, output ready);
endinterface

/* sv/kmid_rsp_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmid_rsp_if
// response channel: changed mask, stable bitmap and scan flag
// ---------------------------------------------------------------------------
interface kmid_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] changed_keys;
   logic [31:0] stable_keys;
   logic        scan_done;

   modport source (output valid, output changed_keys, output stable_keys,
                   output scan_done, input ready);
   modport sink   (input valid, input changed_keys, input stable_keys,
                   input scan_done, output ready);
endinterface

/* sv/kmid_csr.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmid_csr
// apb-style register block holding scan period and press threshold
// ---------------------------------------------------------------------------
module kmid_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [kmid_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [kmid_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [kmid_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready,
   output kmid_pkg::cfg_type            cfg
);
   import kmid_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_SCAN_PERIOD:     cfg_in.scan_period = csr_pwdata[PERIOD_WIDTH-1:0];
            REG_PRESS_THRESHOLD: cfg_in.press_threshold = csr_pwdata[COUNT_WIDTH-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SCAN_PERIOD:     csr_prdata = {{(CSR_DW-PERIOD_WIDTH){1'b0}}, cfg_ff.scan_period};
         REG_PRESS_THRESHOLD: csr_prdata = {{(CSR_DW-COUNT_WIDTH){1'b0}},
                                            cfg_ff.press_threshold};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_period     <= PERIOD_RESET;
         cfg_ff.press_threshold <= THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

/* sv/kmid_key_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmid_key_cell
// one key: saturating up/down integrator and its debounced state
// ---------------------------------------------------------------------------
module kmid_key_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              scan,
   input  logic                              raw,
   input  logic [kmid_pkg::COUNT_WIDTH-1:0]  threshold,
   output logic                              stable_cur,
   output logic                              stable_nxt
);
   import kmid_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   stable_ff;

   always_comb begin
      if (raw) begin
         count_in   = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
         stable_nxt = stable_ff || (count_in >= threshold);
      end else begin
         count_in   = (count_ff == '0) ? count_ff : count_ff - 1'b1;
         stable_nxt = stable_ff && (count_in != '0);
      end
   end

   assign stable_cur = stable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         stable_ff <= 1'b0;
      end else if (scan) begin
         count_ff  <= count_in;
         stable_ff <= stable_nxt;
      end
   end
endmodule

/* sv/key_matrix_integrating_debouncer_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_matrix_integrating_debouncer_unit
// integrating debouncer over a decoded key bitmap, gated by a scan period
// ---------------------------------------------------------------------------
// a request beat passes the input register and then the result register before it leaves as a response beat
// throughput: one beat per cycle while the response channel does not stall; all key integrators update in parallel
// the per-key integrator and stable bit close a feedback loop, as does the last scan time
// reset: synchronous, clears integrators, stable bitmap, last scan time
// and both channel valid flags; scan period 1 and threshold 5 after reset
module key_matrix_integrating_debouncer_unit #(
   parameter int unsigned NUM_KEYS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   kmid_req_if.sink                     req_bus,
   kmid_rsp_if.source                   rsp_bus,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [kmid_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [kmid_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [kmid_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import kmid_pkg::*;

   cfg_type                cfg;
   logic                   in_valid_ff;
   logic [TIME_WIDTH-1:0]  in_time_ff;
   logic [KEY_WIDTH-1:0]   in_raw_ff;
   logic [TIME_WIDTH-1:0]  last_scan_ff;
   logic                   out_valid_ff;
   logic [KEY_WIDTH-1:0]   out_changed_ff;
   logic [KEY_WIDTH-1:0]   out_stable_ff;
   logic                   out_scan_ff;
   logic [TIME_WIDTH-1:0]  elapsed;
   logic                   advance;
   logic                   due;
   logic                   scan;
   logic [KEY_WIDTH-1:0]   stable_cur;
   logic [KEY_WIDTH-1:0]   stable_nxt;

   kmid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign advance = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign elapsed = in_time_ff - last_scan_ff;
   assign due     = elapsed >= {{(TIME_WIDTH-PERIOD_WIDTH){1'b0}}, cfg.scan_period};
   assign scan    = advance && due;

   assign req_bus.ready = !in_valid_ff || advance;

   genvar k;
   generate
      for (k = 0; k < KEY_WIDTH; k++) begin : g_key
         if (k < NUM_KEYS) begin : g_cell
            kmid_key_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .scan       (scan),
               .raw        (in_raw_ff[k]),
               .threshold  (cfg.press_threshold),
               .stable_cur (stable_cur[k]),
               .stable_nxt (stable_nxt[k])
            );
         end else begin : g_none
            assign stable_cur[k] = 1'b0;
            assign stable_nxt[k] = 1'b0;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_scan_ff <= '0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (scan) begin
            last_scan_ff <= in_time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_time_ff <= req_bus.time_ms;
         in_raw_ff  <= req_bus.raw_pressed;
      end
      if (advance) begin
         out_scan_ff    <= due;
         out_changed_ff <= due ? (stable_nxt ^ stable_cur) : '0;
         out_stable_ff  <= due ? stable_nxt : stable_cur;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.changed_keys = out_changed_ff;
   assign rsp_bus.stable_keys  = out_stable_ff;
   assign rsp_bus.scan_done    = out_scan_ff;
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench for the key matrix integrating debouncer. Timestamped key bitmaps
// go in on the request channel. A behavioural copy of the scan gate, the
// per-key up/down counters and the stable bitmap predicts every response.
// The tests run through several scan periods and press thresholds, the
// extremes among them. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb;
   import kmid_pkg::*;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] changed_keys;
      logic [KEY_WIDTH-1:0] stable_keys;
      logic                 scan_done;
   } debounce_result_type;

   logic clock;
   logic reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   kmid_req_if req_bus ();
   kmid_rsp_if rsp_bus ();

   key_matrix_integrating_debouncer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic [PERIOD_WIDTH-1:0] period_model    = PERIOD_RESET;
   logic [COUNT_WIDTH-1:0]  threshold_model = THRESHOLD_RESET;
   logic [TIME_WIDTH-1:0]   last_scan_model = '0;
   logic [KEY_WIDTH-1:0]    stable_model    = '0;
   logic [COUNT_WIDTH-1:0]  key_level [KEY_WIDTH] = '{default: '0};

   debounce_result_type pending_results[$];

   int  mismatch_count = 0;
   int  beats_sent     = 0;
   int  results_seen   = 0;
   int  scans_seen     = 0;
   int  settings_used  = 0;
   bit  idle_on        = 0;
   int  stall_left     = 0;

   logic [TIME_WIDTH-1:0] now_ms;
   logic [KEY_WIDTH-1:0]  held_keys;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("tb failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 30)
         $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
   endtask

   function automatic debounce_result_type integrate_scan(
      input logic [TIME_WIDTH-1:0] now,
      input logic [KEY_WIDTH-1:0] raw);
      debounce_result_type   r;
      logic [TIME_WIDTH-1:0] elapsed;
      logic [KEY_WIDTH-1:0]  next;
      r.changed_keys = '0;
      r.stable_keys  = stable_model;
      r.scan_done    = 1'b0;
      elapsed = now - last_scan_model;
      if (elapsed < {16'd0, period_model})
         return r;
      last_scan_model = now;
      next = stable_model;
      for (int k = 0; k < KEY_WIDTH; k++) begin
         if (raw[k]) begin
            if (key_level[k] != COUNT_MAX)
               key_level[k] = key_level[k] + 1'b1;
            if (key_level[k] >= threshold_model)
               next[k] = 1'b1;
         end else begin
            if (key_level[k] != '0)
               key_level[k] = key_level[k] - 1'b1;
            if (key_level[k] == '0)
               next[k] = 1'b0;
         end
      end
      r.changed_keys = next ^ stable_model;
      r.stable_keys  = next;
      r.scan_done    = 1'b1;
      stable_model   = next;
      return r;
   endfunction

   // response side: random stall after each beat, result check
   always @(posedge clock) begin
      debounce_result_type want;
      if (reset) begin
         stall_left = 0;
         rsp_bus.ready <= 1'b1;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected beat", rsp_bus.stable_keys, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.scan_done)
                  scans_seen++;
               if (rsp_bus.changed_keys !== want.changed_keys)
                  report_mismatch("changed_keys", rsp_bus.changed_keys, want.changed_keys);
               if (rsp_bus.stable_keys !== want.stable_keys)
                  report_mismatch("stable_keys", rsp_bus.stable_keys, want.stable_keys);
               if (rsp_bus.scan_done !== want.scan_done)
                  report_mismatch("scan_done", {31'd0, rsp_bus.scan_done},
                                  {31'd0, want.scan_done});
            end
            stall_left = idle_on ? $urandom_range(0, 5) : 0;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   task automatic send_scan(input logic [TIME_WIDTH-1:0] stamp,
                            input logic [KEY_WIDTH-1:0] raw);
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.time_ms     <= stamp;
      req_bus.raw_pressed <= raw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results.push_back(integrate_scan(stamp, raw));
      beats_sent++;
   endtask

   task automatic wait_idle();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input reg_index_type idx, input bit is_write,
                             input logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_settings();
      logic [CSR_DW-1:0] rdata;
      csr_access(REG_SCAN_PERIOD, 1'b0, '0, rdata);
      if (rdata[PERIOD_WIDTH-1:0] !== period_model)
         report_mismatch("scan_period readback", rdata, {16'd0, period_model});
      csr_access(REG_PRESS_THRESHOLD, 1'b0, '0, rdata);
      if (rdata[COUNT_WIDTH-1:0] !== threshold_model)
         report_mismatch("press_threshold readback", rdata, {24'd0, threshold_model});
   endtask

   task automatic apply_settings(input logic [PERIOD_WIDTH-1:0] period,
                                 input logic [COUNT_WIDTH-1:0] threshold,
                                 input bit idle);
      logic [CSR_DW-1:0] rdata;
      wait_idle();
      csr_access(REG_SCAN_PERIOD, 1'b1, {16'd0, period}, rdata);
      period_model = period;
      csr_access(REG_PRESS_THRESHOLD, 1'b1, {24'd0, threshold}, rdata);
      threshold_model = threshold;
      check_settings();
      idle_on = idle;
      settings_used++;
   endtask

   // bouncy keys: a held pattern with sparse flips, the odd garbage beat,
   // early beats inside the period and the odd large time jump
   task automatic run_bouncing_keys(input int count);
      logic [TIME_WIDTH-1:0] delta;
      logic [KEY_WIDTH-1:0]  raw;
      repeat (count) begin
         case ($urandom_range(0, 15))
            0:       delta = $urandom;
            1, 2:    delta = (period_model == 0) ? '0 :
                             $urandom_range(0, period_model - 1);
            default: delta = period_model + $urandom_range(0, 3);
         endcase
         now_ms = now_ms + delta;
         if ($urandom_range(0, 63) == 0)
            held_keys = held_keys ^ ($urandom & $urandom);
         if ($urandom_range(0, 15) == 0)
            raw = $urandom;
         else
            raw = held_keys ^ ($urandom & $urandom & $urandom & $urandom);
         send_scan(now_ms, raw);
      end
   endtask

   task automatic test_reset_values();
      check_settings();
   endtask

   task automatic test_directed_edges();
      idle_on = 0;
      send_scan(32'd0, '1);                 // first beat at time zero: no scan
      send_scan(32'd1, '1);
      send_scan(32'd1, '1);                 // same time again: no scan
      for (int t = 2; t <= 5; t++)
         send_scan(t, '1);                  // reaches the default threshold
      send_scan(32'd6, '0);                 // between levels, stable holds
      send_scan(32'd7, 32'hAAAA_AAAA);
      send_scan(32'hFFFF_FFFF, 32'h5555_5555);
      send_scan(32'd3, '0);                 // time wraps past zero
      apply_settings(16'd0, 8'd0, 1'b0);
      send_scan(32'd3, 32'h8000_0001);      // zero threshold presses at once
      send_scan(32'd3, '0);
      send_scan(32'd3, '0);
      apply_settings(16'hFFFF, 8'hFF, 1'b1);
      send_scan(32'd3 + 32'd65534, '1);     // one short of the period
      send_scan(32'd3 + 32'd65535, '1);
      send_scan(32'd3 + 32'd131070, 32'h0000_FFFF);
      send_scan(32'hFFFF_FFFF, 32'hFFFF_0000);
      now_ms = 32'hFFFF_FFFF;
   endtask

   task automatic test_fast_scan_saturation();
      apply_settings(16'd0, 8'hFF, 1'b0);
      held_keys = $urandom;
      run_bouncing_keys(400);
   endtask

   task automatic test_zero_threshold_long_period();
      apply_settings(16'hFFFF, 8'd0, 1'b1);
      held_keys = $urandom;
      run_bouncing_keys(150);
   endtask

   task automatic test_unit_period_min_threshold();
      apply_settings(16'd1, 8'd1, 1'b1);
      held_keys = $urandom;
      run_bouncing_keys(150);
   endtask

   task automatic test_random_settings();
      repeat (4) begin
         apply_settings(PERIOD_WIDTH'($urandom_range(0, 12)),
                        COUNT_WIDTH'($urandom_range(1, 12)),
                        1'($urandom_range(0, 1)));
         held_keys = $urandom;
         run_bouncing_keys(50);
      end
   endtask

   task automatic test_wide_period_wrap();
      apply_settings(PERIOD_WIDTH'($urandom), COUNT_WIDTH'($urandom_range(1, 255)), 1'b1);
      now_ms = 32'hFFFF_0000 + $urandom_range(0, 255);
      held_keys = $urandom;
      run_bouncing_keys(150);
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.time_ms     = '0;
      req_bus.raw_pressed = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      now_ms              = '0;
      held_keys           = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_directed_edges();
      test_fast_scan_saturation();
      test_zero_threshold_long_period();
      test_unit_period_min_threshold();
      test_random_settings();
      test_wide_period_wrap();
      wait_idle();
      if (pending_results.size() != 0)
         report_mismatch("results never arrived", pending_results.size(), 0);

      $display("sent %0d key bitmaps, checked %0d results, %0d of them scans",
               beats_sent, results_seen, scans_seen);
      $display("covered %0d register settings incl. zero and full-scale period and threshold",
               settings_used);
      if (mismatch_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
